// ===== rtl/ihex_pkg.sv =====
// Shared types and codes for the Intel HEX record decoder.
// No dependencies; every other file uses this package by scoped names.
package ihex_pkg;

	localparam int unsigned MAX_RECORD_BYTES_DEF = 512;

	// byte positions within a record
	localparam int unsigned POS_COUNT     = 0;
	localparam int unsigned POS_ADDR_HI   = 1;
	localparam int unsigned POS_ADDR_LO   = 2;
	localparam int unsigned POS_TYPE      = 3;
	localparam int unsigned POS_EXT_HI    = 4;
	localparam int unsigned POS_EXT_LO    = 5;
	localparam int unsigned PAYLOAD_START = 4;
	localparam int unsigned MIN_RECORD    = 5;

	localparam logic [7:0] EXT_COUNT = 8'd2;

	localparam logic KIND_DATA   = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	localparam logic [7:0] RT_DATA      = 8'h00;
	localparam logic [7:0] RT_EOF       = 8'h01;
	localparam logic [7:0] RT_EXT_SEG   = 8'h02;
	localparam logic [7:0] RT_START_SEG = 8'h03;
	localparam logic [7:0] RT_EXT_LIN   = 8'h04;
	localparam logic [7:0] RT_START_LIN = 8'h05;

	localparam logic [3:0] ST_DATA_OK       = 4'd0;
	localparam logic [3:0] ST_SEGMENT_SET   = 4'd1;
	localparam logic [3:0] ST_LINEAR_SET    = 4'd2;
	localparam logic [3:0] ST_EOF           = 4'd3;
	localparam logic [3:0] ST_START_SKIPPED = 4'd4;
	localparam logic [3:0] ST_UNKNOWN_TYPE  = 4'd5;
	localparam logic [3:0] ST_TOO_SHORT     = 4'd6;
	localparam logic [3:0] ST_BAD_CHECKSUM  = 4'd7;
	localparam logic [3:0] ST_BAD_COUNT     = 4'd8;
	localparam logic [3:0] ST_IGNORED       = 4'd9;

	typedef struct packed {
		logic [7:0] rec_byte;
		logic       end_of_record;
	} ihex_in_t;

	typedef struct packed {
		logic        kind;
		logic [31:0] target_address;
		logic [7:0]  data_byte;
		logic [7:0]  record_type;
		logic [3:0]  status;
	} ihex_out_t;

	// core to register stages
	typedef struct packed {
		logic advance;
		logic res_valid;
	} ihex_flow_t;

endpackage

// ===== rtl/ihex_in_reg.sv =====
// Input register stage: holds one accepted item for the decode core.
// Depends on ihex_pkg.
module ihex_in_reg (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 byte_valid,
	input  ihex_pkg::ihex_in_t   byte_item,
	output logic                 byte_stall,
	input  ihex_pkg::ihex_flow_t flow,
	output logic                 valid_s1,
	output ihex_pkg::ihex_in_t   item_s1
);

	assign byte_stall = valid_s1 && !flow.advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!byte_stall && byte_valid) begin
			item_s1 <= byte_item;
		end
	end

endmodule

// ===== rtl/ihex_core.sv =====
// Record state and decode: byte tracking, checksum, bases and result build.
// Depends on ihex_pkg.
module ihex_core #(
	parameter int unsigned MAX_RECORD_BYTES = ihex_pkg::MAX_RECORD_BYTES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 valid_s1,
	input  ihex_pkg::ihex_in_t   item_s1,
	input  logic                 out_free,
	output ihex_pkg::ihex_flow_t flow,
	output ihex_pkg::ihex_out_t  res
);

	localparam int unsigned POS_W = $clog2(MAX_RECORD_BYTES + 1);
	localparam int unsigned CMP_W = (POS_W > 8) ? POS_W : 8;

	logic [POS_W-1:0] pos_q;
	logic [7:0]       sum_q;
	logic [7:0]       count_q;
	logic [15:0]      addr_q;
	logic [7:0]       type_q;
	logic [15:0]      ext_q;
	logic [15:0]      linear_q;
	logic [19:0]      seg_q;
	logic             halted_q;

	logic [7:0]       b;
	logic             eor;
	logic             in_range;
	logic [POS_W-1:0] pos_n;
	logic [POS_W-1:0] offset;
	logic [7:0]       sum_n;
	logic [7:0]       count_n;
	logic [15:0]      addr_n;
	logic [7:0]       type_n;
	logic [15:0]      ext_n;
	logic             is_data;
	logic [31:0]      addr_sum;
	logic [3:0]       st;
	logic             halt_set;
	logic             seg_set;
	logic             lin_set;

	assign b        = item_s1.rec_byte;
	assign eor      = item_s1.end_of_record;
	assign in_range = pos_q < POS_W'(MAX_RECORD_BYTES);
	assign offset   = pos_q - POS_W'(ihex_pkg::PAYLOAD_START);

	always_comb begin
		pos_n   = pos_q;
		sum_n   = sum_q;
		count_n = count_q;
		addr_n  = addr_q;
		type_n  = type_q;
		ext_n   = ext_q;
		if (in_range) begin
			pos_n = pos_q + POS_W'(1);
			sum_n = sum_q + b;
			if (pos_q == POS_W'(ihex_pkg::POS_COUNT)) begin
				count_n = b;
			end
			if (pos_q == POS_W'(ihex_pkg::POS_ADDR_HI)) begin
				addr_n = {b, addr_q[7:0]};
			end
			if (pos_q == POS_W'(ihex_pkg::POS_ADDR_LO)) begin
				addr_n = {addr_q[15:8], b};
			end
			if (pos_q == POS_W'(ihex_pkg::POS_TYPE)) begin
				type_n = b;
			end
			if (pos_q == POS_W'(ihex_pkg::POS_EXT_HI)) begin
				ext_n = {b, ext_q[7:0]};
			end
			if (pos_q == POS_W'(ihex_pkg::POS_EXT_LO)) begin
				ext_n = {ext_q[15:8], b};
			end
		end
	end

	assign is_data = in_range && !eor && !halted_q && (type_q == ihex_pkg::RT_DATA) &&
		(pos_q >= POS_W'(ihex_pkg::PAYLOAD_START)) && (CMP_W'(offset) < CMP_W'(count_q));

	assign addr_sum = {linear_q, 16'h0000} + {16'h0000, addr_n} + {12'h000, seg_q} +
		(is_data ? 32'(offset) : 32'h0000_0000);

	always_comb begin
		st       = ihex_pkg::ST_DATA_OK;
		halt_set = 1'b0;
		seg_set  = 1'b0;
		lin_set  = 1'b0;
		if (halted_q) begin
			st = ihex_pkg::ST_IGNORED;
		end else if (pos_n < POS_W'(ihex_pkg::MIN_RECORD)) begin
			st       = ihex_pkg::ST_TOO_SHORT;
			halt_set = 1'b1;
		end else if (sum_n != 8'h00) begin
			st       = ihex_pkg::ST_BAD_CHECKSUM;
			halt_set = 1'b1;
		end else begin
			case (type_n)
				ihex_pkg::RT_DATA: begin
					st = ihex_pkg::ST_DATA_OK;
				end
				ihex_pkg::RT_EOF: begin
					st       = ihex_pkg::ST_EOF;
					halt_set = 1'b1;
				end
				ihex_pkg::RT_EXT_SEG: begin
					if (count_n != ihex_pkg::EXT_COUNT) begin
						st       = ihex_pkg::ST_BAD_COUNT;
						halt_set = 1'b1;
					end else begin
						st      = ihex_pkg::ST_SEGMENT_SET;
						seg_set = 1'b1;
					end
				end
				ihex_pkg::RT_EXT_LIN: begin
					if (count_n != ihex_pkg::EXT_COUNT) begin
						st       = ihex_pkg::ST_BAD_COUNT;
						halt_set = 1'b1;
					end else begin
						st      = ihex_pkg::ST_LINEAR_SET;
						lin_set = 1'b1;
					end
				end
				ihex_pkg::RT_START_SEG, ihex_pkg::RT_START_LIN: begin
					st = ihex_pkg::ST_START_SKIPPED;
				end
				default: begin
					st = ihex_pkg::ST_UNKNOWN_TYPE;
				end
			endcase
		end
	end

	always_comb begin
		if (is_data) begin
			res.kind           = ihex_pkg::KIND_DATA;
			res.target_address = addr_sum;
			res.data_byte      = b;
			res.record_type    = 8'h00;
			res.status         = ihex_pkg::ST_DATA_OK;
		end else begin
			res.kind           = ihex_pkg::KIND_STATUS;
			res.target_address = halted_q ? 32'h0000_0000 : addr_sum;
			res.data_byte      = 8'h00;
			res.record_type    = type_n;
			res.status         = st;
		end
	end

	assign flow.res_valid = is_data || eor;
	assign flow.advance   = valid_s1 && (!flow.res_valid || out_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			sum_q    <= '0;
			count_q  <= '0;
			addr_q   <= '0;
			type_q   <= '0;
			ext_q    <= '0;
			linear_q <= '0;
			seg_q    <= '0;
			halted_q <= 1'b0;
		end else if (flow.advance) begin
			if (eor) begin
				pos_q   <= '0;
				sum_q   <= '0;
				count_q <= '0;
				addr_q  <= '0;
				type_q  <= '0;
				ext_q   <= '0;
				if (halt_set) begin
					halted_q <= 1'b1;
				end
				if (seg_set) begin
					seg_q <= {ext_n, 4'h0};
				end
				if (lin_set) begin
					linear_q <= ext_n;
				end
			end else begin
				pos_q   <= pos_n;
				sum_q   <= sum_n;
				count_q <= count_n;
				addr_q  <= addr_n;
				type_q  <= type_n;
				ext_q   <= ext_n;
			end
		end
	end

endmodule

// ===== rtl/ihex_out_reg.sv =====
// Result register stage: holds one result item until the sink takes it.
// Depends on ihex_pkg.
module ihex_out_reg (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ihex_pkg::ihex_flow_t flow,
	input  ihex_pkg::ihex_out_t  res,
	output logic                 out_free,
	output logic                 valid_s2,
	output ihex_pkg::ihex_out_t  item_s2,
	input  logic                 result_stall
);

	logic load;

	assign out_free = !valid_s2 || !result_stall;
	assign load     = out_free && flow.advance && flow.res_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s2 <= res;
		end
	end

endmodule

// ===== rtl/intel_hex_record_decoder_unit.sv =====
// Intel HEX record decoder. Bytes are held in the input register, results in the
// result register. Throughput: one byte per cycle unless stalled; the input register,
// decode core and result register let a new byte in while a result waits to be taken.
// Reset (arst_n low, asynchronous): record state, address bases and halt flag clear.
// Depends on ihex_pkg, ihex_in_reg, ihex_core, ihex_out_reg.
module intel_hex_record_decoder_unit #(
	parameter int unsigned MAX_RECORD_BYTES = ihex_pkg::MAX_RECORD_BYTES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	output logic                byte_stall,
	input  ihex_pkg::ihex_in_t  byte_item,
	output logic                result_valid,
	input  logic                result_stall,
	output ihex_pkg::ihex_out_t result_item
);

	ihex_pkg::ihex_flow_t flow;
	ihex_pkg::ihex_in_t   item_s1;
	ihex_pkg::ihex_out_t  res;
	logic                 valid_s1;
	logic                 out_free;

	ihex_in_reg u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_item  (byte_item),
		.byte_stall (byte_stall),
		.flow       (flow),
		.valid_s1   (valid_s1),
		.item_s1    (item_s1)
	);

	ihex_core #(
		.MAX_RECORD_BYTES (MAX_RECORD_BYTES)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1),
		.out_free (out_free),
		.flow     (flow),
		.res      (res)
	);

	ihex_out_reg u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.flow         (flow),
		.res          (res),
		.out_free     (out_free),
		.valid_s2     (result_valid),
		.item_s2      (result_item),
		.result_stall (result_stall)
	);

endmodule

// ===== rtl/ihex_checker.sv =====
// Port-level checks for intel_hex_record_decoder_unit, bound to the top level.
// Depends on ihex_pkg.
module ihex_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                byte_valid,
	input logic                byte_stall,
	input ihex_pkg::ihex_in_t  byte_item,
	input logic                result_valid,
	input logic                result_stall,
	input ihex_pkg::ihex_out_t result_item
);

	logic halting_status;

	assign halting_status = result_valid && !result_stall &&
		(result_item.kind == ihex_pkg::KIND_STATUS) &&
		((result_item.status == ihex_pkg::ST_EOF) ||
		 (result_item.status == ihex_pkg::ST_TOO_SHORT) ||
		 (result_item.status == ihex_pkg::ST_BAD_CHECKSUM) ||
		 (result_item.status == ihex_pkg::ST_BAD_COUNT) ||
		 (result_item.status == ihex_pkg::ST_IGNORED));

	a_item_hold: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && byte_stall |=> byte_valid && $stable(byte_item))
		else $error("stalled byte item changed");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result_item))
		else $error("stalled result item changed");

	a_empty_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> !byte_stall)
		else $error("byte stalled with empty result register");

	a_result_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(byte_valid && !byte_stall, 2))
		else $error("result without a byte accepted two cycles earlier");

	a_halt_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		halting_status |=> !result_valid ||
			((result_item.kind == ihex_pkg::KIND_STATUS) &&
			 (result_item.status == ihex_pkg::ST_IGNORED) &&
			 (result_item.target_address == 32'h0000_0000)))
		else $error("result other than ignored after halt");

endmodule

bind intel_hex_record_decoder_unit ihex_checker u_ihex_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.byte_valid   (byte_valid),
	.byte_stall   (byte_stall),
	.byte_item    (byte_item),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result_item  (result_item)
);
